/* hw/rtl/hic_pkg.sv */
`default_nettype none

package hic_pkg;

  // field and register widths
  localparam int CW    = 48;            // coefficient, signed Q16.32
  localparam int PW    = 16;            // point coordinate, unsigned 12.4
  localparam int CNTW  = 13;            // inlier count
  localparam int REGW  = 3;             // register index
  localparam int HALF  = 24;            // coefficient split for the lane multipliers
  localparam int NLANE = 3;             // x, y and w lanes

  // datapath widths
  localparam int AW    = 68;            // homogeneous x, y, w (|value| < 2^66)
  localparam int VW    = 72;            // 48 * |w|
  localparam int DXW   = 88;            // 16*x - lx*w (|value| < 2^83)
  localparam int LIMB  = 32;
  localparam int NLIMB = 3;
  localparam int SQW   = LIMB * NLIMB;  // square operand
  localparam int DW    = 172;           // dx^2 + dy^2 - (48w)^2 (|value| < 2^167)
  localparam int MW    = LIMB + 1;      // shared multiplier operand
  localparam int PRW   = 2 * MW;        // shared multiplier product
  localparam int SHW   = 8;             // product shift amount

  localparam int CNT_MAX = 2 ** CNTW - 1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // 1.0 of w scaled by 2^36
  localparam logic [AW-1:0] W_ONE = {{(AW - 37){1'b0}}, 1'b1, 36'b0};
  localparam logic [CW-1:0] COEF_ONE = {{(CW - 33){1'b0}}, 1'b1, 32'b0};

  typedef enum logic [REGW-1:0] {
    REG_XX = 3'd0,
    REG_XY = 3'd1,
    REG_XT = 3'd2,
    REG_YX = 3'd3,
    REG_YY = 3'd4,
    REG_YT = 3'd5,
    REG_WX = 3'd6,
    REG_WY = 3'd7
  } hic_reg_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DRAIN,
    F_ABS,
    F_PUSH
  } hic_fstate_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LW,
    B_LW_DRAIN,
    B_ABS,
    B_SQ,
    B_SQ_DRAIN,
    B_EMIT
  } hic_bstate_e;

  typedef enum logic [1:0] {
    DEST_DX,
    DEST_DY,
    DEST_ERR
  } hic_dest_e;

  typedef struct packed {
    logic signed [CW-1:0] xx;
    logic signed [CW-1:0] xy;
    logic signed [CW-1:0] xt;
    logic signed [CW-1:0] yx;
    logic signed [CW-1:0] yy;
    logic signed [CW-1:0] yt;
    logic signed [CW-1:0] wx;
    logic signed [CW-1:0] wy;
  } hic_coef_t;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] w;
    logic [VW-1:0]        v;
    logic                 w_zero;
    logic [PW-1:0]        lx;
    logic [PW-1:0]        ly;
    logic                 last;
  } hic_entry_t;

  typedef struct packed {
    logic           valid;
    hic_dest_e      dest;
    logic           neg;
    logic [SHW-1:0] sh;
  } hic_ptag_t;

endpackage

`default_nettype wire

/* hw/rtl/hic_if.sv */
`default_nettype none

interface hic_in_if import hic_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] left_x;
  logic [PW-1:0] left_y;
  logic [PW-1:0] right_x;
  logic [PW-1:0] right_y;
  logic          last_pair;

  modport source (output valid, left_x, left_y, right_x, right_y, last_pair, input ready);
  modport sink (input valid, left_x, left_y, right_x, right_y, last_pair, output ready);
endinterface

interface hic_out_if import hic_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            is_inlier;
  logic [CNTW-1:0] inlier_count;
  logic            pass_done;

  modport source (output valid, is_inlier, inlier_count, pass_done, input ready);
  modport sink (input valid, is_inlier, inlier_count, pass_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hic_front.sv */
`default_nettype none

module hic_front import hic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hic_coef_t  coef_i,
  hic_in_if.sink     pair_i,
  output logic       push_o,
  output hic_entry_t push_data_o,
  input  logic       full_i
);

  hic_fstate_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        pvalid_q, pvalid_d;
  logic        psh_q, psh_d;

  logic [PW-1:0] lx_q, ly_q, rx_q, ry_q;
  logic          last_q;

  logic signed [CW-1:0]   coef_a [NLANE];
  logic signed [CW-1:0]   coef_b [NLANE];
  logic signed [CW-1:0]   cf     [NLANE];
  logic signed [HALF:0]   half   [NLANE];
  logic [PW-1:0]          pt;
  logic signed [41:0]     prod_q [NLANE];
  logic signed [41:0]     prod_d [NLANE];
  logic signed [AW-1:0]   acc_q  [NLANE];
  logic signed [AW-1:0]   acc_d  [NLANE];
  logic [AW-1:0]          wabs_q;
  logic                   wzero_q;

  assign coef_a[0] = coef_i.xx;
  assign coef_b[0] = coef_i.xy;
  assign coef_a[1] = coef_i.yx;
  assign coef_b[1] = coef_i.yy;
  assign coef_a[2] = coef_i.wx;
  assign coef_b[2] = coef_i.wy;

  // step[1] picks the coefficient and coordinate, step[0] the coefficient half
  assign pt = step_q[1] ? ry_q : rx_q;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    pvalid_d      = 1'b0;
    psh_d         = step_q[0];
    pair_i.ready  = 1'b0;
    push_o        = 1'b0;

    for (int l = 0; l < NLANE; l++) begin
      cf[l]     = step_q[1] ? coef_b[l] : coef_a[l];
      half[l]   = step_q[0] ? {cf[l][CW-1], cf[l][CW-1:HALF]} : {1'b0, cf[l][HALF-1:0]};
      prod_d[l] = 42'(half[l]) * 42'($signed({1'b0, pt}));
      acc_d[l]  = acc_q[l];
      if (pvalid_q) begin
        acc_d[l] = acc_q[l] + ({{(AW - 42){prod_q[l][41]}}, prod_q[l]} << (psh_q ? HALF : 0));
      end
    end

    case (state_q)
      F_IDLE: begin
        pair_i.ready = 1'b1;
        if (pair_i.valid) begin
          acc_d[0] = {{(AW - CW - 4){coef_i.xt[CW-1]}}, coef_i.xt, 4'b0};
          acc_d[1] = {{(AW - CW - 4){coef_i.yt[CW-1]}}, coef_i.yt, 4'b0};
          acc_d[2] = W_ONE;
          step_d   = '0;
          state_d  = F_MUL;
        end
      end
      F_MUL: begin
        pvalid_d = 1'b1;
        step_d   = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = F_DRAIN;
        end
      end
      F_DRAIN: begin
        state_d = F_ABS;
      end
      F_ABS: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      step_q   <= '0;
      pvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pvalid_q <= pvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    psh_q <= psh_d;
    for (int l = 0; l < NLANE; l++) begin
      prod_q[l] <= prod_d[l];
      acc_q[l]  <= acc_d[l];
    end
    if (state_q == F_IDLE && pair_i.valid) begin
      lx_q   <= pair_i.left_x;
      ly_q   <= pair_i.left_y;
      rx_q   <= pair_i.right_x;
      ry_q   <= pair_i.right_y;
      last_q <= pair_i.last_pair;
    end
    if (state_q == F_ABS) begin
      wabs_q  <= acc_q[2][AW-1] ? AW'(-acc_q[2]) : AW'(acc_q[2]);
      wzero_q <= (acc_q[2] == '0);
    end
  end

  // bound uses (48*|w|)^2 = 2304*w^2
  always_comb begin
    push_data_o.x      = acc_q[0];
    push_data_o.y      = acc_q[1];
    push_data_o.w      = acc_q[2];
    push_data_o.v      = VW'({wabs_q, 5'b0}) + VW'({wabs_q, 4'b0});
    push_data_o.w_zero = wzero_q;
    push_data_o.lx     = lx_q;
    push_data_o.ly     = ly_q;
    push_data_o.last   = last_q;
  end

endmodule

`default_nettype wire

/* hw/rtl/hic_queue.sv */
`default_nettype none

module hic_queue import hic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hic_entry_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output hic_entry_t data_o
);

  hic_entry_t       mem_q [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNTW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNTW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hic_back.sv */
`default_nettype none

module hic_back import hic_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  output logic       pop_o,
  input  hic_entry_t ent_i,
  hic_out_if.source  result_o
);

  localparam int unsigned CapInt = (MAX_PAIRS < CNT_MAX) ? MAX_PAIRS : CNT_MAX;
  localparam logic [CNTW-1:0] CountCap = CNTW'(CapInt);

  hic_bstate_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [1:0]  opnd_q, opnd_d;

  hic_entry_t             ent_q;
  logic signed [DXW-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic signed [DW-1:0]   d_q, d_d;
  logic [SQW-1:0]         adx_q, ady_q, v_q;
  logic [DXW-1:0]         adx, ady;

  logic signed [MW-1:0]   ma, mb;
  logic signed [PRW-1:0]  prod_q;
  hic_ptag_t              tag_q, tag_d;
  logic [DW-1:0]          term;

  logic [1:0]     li, ai, aj;
  logic           dbl;
  logic [2:0]     ij;
  logic [SQW-1:0] sq_sel;

  logic            out_valid_q;
  logic            out_inlier_q;
  logic [CNTW-1:0] out_count_q;
  logic            out_done_q;
  logic [CNTW-1:0] cnt_q, cnt_next;
  logic            inlier;
  logic            emit;

  assign adx = dx_q[DXW-1] ? DXW'(-dx_q) : DXW'(dx_q);
  assign ady = dy_q[DXW-1] ? DXW'(-dy_q) : DXW'(dy_q);

  // product as a signed term at its limb offset
  assign term = {{(DW - PRW){prod_q[PRW-1]}}, prod_q} << tag_q.sh;

  // limb of w for the lx*w and ly*w products
  assign li = (step_q < 3'd3) ? step_q[1:0] : 2'(step_q - 3'd3);

  // square of a 3-limb value: diagonal terms once, cross terms doubled
  always_comb begin
    case (step_q)
      3'd0:    begin ai = 2'd0; aj = 2'd0; dbl = 1'b0; end
      3'd1:    begin ai = 2'd1; aj = 2'd1; dbl = 1'b0; end
      3'd2:    begin ai = 2'd2; aj = 2'd2; dbl = 1'b0; end
      3'd3:    begin ai = 2'd0; aj = 2'd1; dbl = 1'b1; end
      3'd4:    begin ai = 2'd0; aj = 2'd2; dbl = 1'b1; end
      default: begin ai = 2'd1; aj = 2'd2; dbl = 1'b1; end
    endcase
    case (opnd_q)
      2'd0:    sq_sel = adx_q;
      2'd1:    sq_sel = ady_q;
      default: sq_sel = v_q;
    endcase
    ij = {1'b0, ai} + {1'b0, aj};
  end

  assign inlier   = !ent_q.w_zero && (d_q[DW-1] || (d_q == '0));
  assign cnt_next = (inlier && (cnt_q < CountCap)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    opnd_d  = opnd_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    tag_d   = '{valid: 1'b0, dest: DEST_DX, neg: 1'b0, sh: '0};
    ma      = '0;
    mb      = '0;
    dx_d    = dx_q;
    dy_d    = dy_q;
    d_d     = d_q;

    if (tag_q.valid) begin
      case (tag_q.dest)
        DEST_DX: dx_d = tag_q.neg ? dx_q - term[DXW-1:0] : dx_q + term[DXW-1:0];
        DEST_DY: dy_d = tag_q.neg ? dy_q - term[DXW-1:0] : dy_q + term[DXW-1:0];
        default: d_d  = tag_q.neg ? d_q - term : d_q + term;
      endcase
    end

    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          dx_d    = {{(DXW - AW - 4){ent_i.x[AW-1]}}, ent_i.x, 4'b0};
          dy_d    = {{(DXW - AW - 4){ent_i.y[AW-1]}}, ent_i.y, 4'b0};
          step_d  = '0;
          state_d = B_LW;
        end
      end
      B_LW: begin
        ma = (step_q < 3'd3) ? MW'($signed({1'b0, ent_q.lx})) : MW'($signed({1'b0, ent_q.ly}));
        case (li)
          2'd0:    mb = $signed({1'b0, ent_q.w[LIMB-1:0]});
          2'd1:    mb = $signed({1'b0, ent_q.w[2*LIMB-1:LIMB]});
          default: mb = {{(MW - (AW - 2*LIMB)){ent_q.w[AW-1]}}, ent_q.w[AW-1:2*LIMB]};
        endcase
        tag_d.valid = 1'b1;
        tag_d.dest  = (step_q < 3'd3) ? DEST_DX : DEST_DY;
        tag_d.neg   = 1'b1;
        tag_d.sh    = {1'b0, li, 5'b0};
        step_d      = step_q + 3'd1;
        if (step_q == 3'd5) begin
          state_d = B_LW_DRAIN;
        end
      end
      B_LW_DRAIN: begin
        state_d = B_ABS;
      end
      B_ABS: begin
        d_d     = '0;
        step_d  = '0;
        opnd_d  = '0;
        state_d = B_SQ;
      end
      B_SQ: begin
        ma          = $signed({1'b0, sq_sel[LIMB*ai +: LIMB]});
        mb          = $signed({1'b0, sq_sel[LIMB*aj +: LIMB]});
        tag_d.valid = 1'b1;
        tag_d.dest  = DEST_ERR;
        tag_d.neg   = (opnd_q == 2'd2);
        tag_d.sh    = {ij, 4'b0, dbl};
        if (step_q == 3'd5) begin
          step_d = '0;
          opnd_d = opnd_q + 2'd1;
          if (opnd_q == 2'd2) begin
            state_d = B_SQ_DRAIN;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      B_SQ_DRAIN: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          emit    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      opnd_q      <= '0;
      tag_q       <= '{valid: 1'b0, dest: DEST_DX, neg: 1'b0, sh: '0};
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      opnd_q  <= opnd_d;
      tag_q   <= tag_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        cnt_q       <= ent_q.last ? '0 : cnt_next;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PRW'(ma) * PRW'(mb);
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    d_q    <= d_d;
    if (pop_o) begin
      ent_q <= ent_i;
    end
    if (state_q == B_ABS) begin
      adx_q <= SQW'(adx);
      ady_q <= SQW'(ady);
      v_q   <= SQW'(ent_q.v);
    end
    if (emit) begin
      out_inlier_q <= inlier;
      out_count_q  <= cnt_next;
      out_done_q   <= ent_q.last;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.is_inlier    = out_inlier_q;
  assign result_o.inlier_count = out_count_q;
  assign result_o.pass_done    = out_done_q;

endmodule

`default_nettype wire

/* hw/rtl/homography_inlier_counter.sv */
// channel     dir  fields                                         width
// pair_i      in   left_x, left_y, right_x, right_y, last_pair    16/16/16/16/1
// result_o    out  is_inlier, inlier_count, pass_done             1/13/1
// cfg_*       in   cfg_we_i, cfg_idx_i, cfg_data_i                1/3/48
//
// the back end works on one pair at a time: 6 + 18 products on its single 33x33
// multiplier plus load, drain, abs and emit steps; that sets the sustained rate.
// the front end (three 25x17 lane multipliers) runs ahead of the back end through
// a two-entry queue. results leave from an output register.
// reset clears control, the inlier count and sets the identity homography.
`default_nettype none

module homography_inlier_counter import hic_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [REGW-1:0] cfg_idx_i,
  input  logic [CW-1:0]   cfg_data_i,
  hic_in_if.sink          pair_i,
  hic_out_if.source       result_o
);

  hic_coef_t  coef_q;
  logic       push, full, pop, empty;
  hic_entry_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{xx: COEF_ONE, yy: COEF_ONE, default: '0};
    end else if (cfg_we_i) begin
      case (hic_reg_e'(cfg_idx_i))
        REG_XX:  coef_q.xx <= cfg_data_i;
        REG_XY:  coef_q.xy <= cfg_data_i;
        REG_XT:  coef_q.xt <= cfg_data_i;
        REG_YX:  coef_q.yx <= cfg_data_i;
        REG_YY:  coef_q.yy <= cfg_data_i;
        REG_YT:  coef_q.yt <= cfg_data_i;
        REG_WX:  coef_q.wx <= cfg_data_i;
        REG_WY:  coef_q.wy <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .pair_i      (pair_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  hic_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  hic_back #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .pop_o    (pop),
    .ent_i    (pop_data),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
